// ===== hw/rtl/pwm_pkg.sv =====
// ----------------------------------------------------------------------------
// pwm_pkg: shared types and constants of the position window filter
// Coordinate and window widths, register indexes, filter modes and the
// control word that the sequencer hands to each window cell.
// ----------------------------------------------------------------------------
package pwm_pkg;

  localparam int COORD_BITS = 32;
  localparam int WINDOW_MAX = 16;
  localparam int WIN_IDX_W  = $clog2(WINDOW_MAX);
  localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
  localparam int ACC_W      = COORD_BITS + WIN_IDX_W;
  localparam int DIV_CNT_W  = $clog2(ACC_W + 1);
  localparam int NUM_AXES   = 3;

  // configuration port
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_ADDR_W-1:0] REG_FILTER_MODE = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_LEN  = 1'd1;

  // filter modes (code 3 falls through to median)
  localparam logic [1:0] MODE_PASS = 2'd0;
  localparam logic [1:0] MODE_MEAN = 2'd1;

  localparam logic [1:0]     MODE_RESET = MODE_PASS;
  localparam logic [CNT_W-1:0] WLEN_RESET = CNT_W'(8);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef coord_t [NUM_AXES-1:0]        sample_t;
  typedef logic [WIN_IDX_W-1:0]         rank_t;
  typedef rank_t [NUM_AXES-1:0]         rank3_t;

  // control word broadcast along the cell row
  typedef struct packed {
    logic                 shift;
    logic                 rank_clr;
    logic                 rank_en;
    logic [WIN_IDX_W-1:0] bidx;
    sample_t              bval;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/pwm_if.sv =====
// ----------------------------------------------------------------------------
// pwm_if: stream interfaces of the position window filter
// Input word carries one position sample with fix status, output word one
// filtered result.
// ----------------------------------------------------------------------------
interface pwm_in_if;
  logic                   valid;
  logic                   ready;
  logic signed [2:0]      fix_status;
  pwm_pkg::coord_t        pos_x;
  pwm_pkg::coord_t        pos_y;
  pwm_pkg::coord_t        pos_z;

  modport source (output valid, fix_status, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, fix_status, pos_x, pos_y, pos_z, output ready);
endinterface

interface pwm_out_if;
  logic                   valid;
  logic                   ready;
  logic                   fix_flag;
  logic                   pose_valid;
  pwm_pkg::coord_t        out_x;
  pwm_pkg::coord_t        out_y;
  pwm_pkg::coord_t        out_z;

  modport source (output valid, fix_flag, pose_valid, out_x, out_y, out_z,
                  input ready);
  modport sink   (input valid, fix_flag, pose_valid, out_x, out_y, out_z,
                  output ready);
endinterface

// ===== hw/rtl/pwm_cell.sv =====
// ----------------------------------------------------------------------------
// pwm_cell: one entry of the sample window
// Holds one 3D sample, takes its neighbor's sample on a shift, and keeps a
// per-axis rank built by comparing against the broadcast sample.
// ----------------------------------------------------------------------------
module pwm_cell (
  input  logic                          clk,
  input  pwm_pkg::cell_ctrl_t           ctrl,
  input  logic [pwm_pkg::WIN_IDX_W-1:0] my_idx,
  input  pwm_pkg::sample_t              prev_sample,
  output pwm_pkg::sample_t              sample,
  output pwm_pkg::rank3_t               rank
);
  import pwm_pkg::*;

  sample_t sample_r;
  rank3_t  rank_r;
  rank3_t  rank_nxt;

  // count entries that order before this one; ties break on position
  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      rank_nxt[k] = rank_r[k];
      if (ctrl.rank_clr) begin
        rank_nxt[k] = '0;
      end else if (ctrl.rank_en) begin
        if (($signed(ctrl.bval[k]) < $signed(sample_r[k])) ||
            ((ctrl.bval[k] == sample_r[k]) && (ctrl.bidx < my_idx))) begin
          rank_nxt[k] = rank_r[k] + rank_t'(1);
        end
      end
    end
  end

  // advance the window on a shift
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      sample_r <= prev_sample;
    end
    rank_r <= rank_nxt;
  end

  assign sample = sample_r;
  assign rank   = rank_r;

endmodule

// ===== hw/rtl/pwm_div.sv =====
// ----------------------------------------------------------------------------
// pwm_div: serial unsigned divider
// Restoring division of a window sum by the window length, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module pwm_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [pwm_pkg::ACC_W-1:0] dividend,
  input  logic [pwm_pkg::CNT_W-1:0] divisor,
  output logic                      done,
  output logic [pwm_pkg::ACC_W-1:0] quot
);
  import pwm_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0]     rem_r;
  logic [ACC_W-1:0]     quo_r;
  logic [CNT_W-1:0]     dsr_r;
  logic [CNT_W:0]       rem_sh;
  logic                 qbit;
  logic [CNT_W:0]       rem_sub;

  // shift in one dividend bit and try the subtract
  always_comb begin
    rem_sh  = {rem_r, quo_r[ACC_W-1]};
    qbit    = (rem_sh >= {1'b0, dsr_r});
    rem_sub = rem_sh - {1'b0, dsr_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= dividend;
        dsr_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= qbit ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        quo_r <= {quo_r[ACC_W-2:0], qbit};
        cnt_r <= cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(ACC_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

// ===== hw/rtl/position_window_mean_median_unit.sv =====
// ----------------------------------------------------------------------------
// position_window_mean_median_unit: sliding window mean / median of positions
// A row of cells keeps the latest samples; a sequencer sums them for the
// mean (followed by a serial divide) or ranks them for the median.
//
//   port    dir   kind          word
//   in_if   in    valid/ready   fix_status, pos_x, pos_y, pos_z
//   out_if  out   valid/ready   fix_flag, pose_valid, out_x, out_y, out_z
//   cfg_*   in    write only    filter_mode (0), window_len (1)
//
// Flow: no fix, pass-through or window still filling go straight to emit;
// median and mean scan the cell row one entry per cycle, and mean then runs
// the serial divider on the window sums before the result is emitted.
// Reset is synchronous; the window contents are not cleared, only the fill
// count. A new word is taken only when the sequencer is idle; a finished
// result waits in the output register while the next word is taken.
// ----------------------------------------------------------------------------
module position_window_mean_median_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  pwm_in_if.sink                         in_if,
  pwm_out_if.source                      out_if,
  input  logic                           cfg_we,
  input  logic [pwm_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [pwm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pwm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_RANK, S_MED, S_SUM, S_DSTART, S_DIV, S_EMIT
  } state_t;

  state_t               state_r;
  logic [1:0]           mode_r;
  logic [CNT_W-1:0]     wlen_r;
  logic [CNT_W-1:0]     fill_r;
  logic [WIN_IDX_W-1:0] idx_r;
  logic signed [ACC_W-1:0] acc_r [NUM_AXES];

  logic                 res_fixed_r;
  logic                 res_pose_r;
  sample_t              res_r;

  logic                 out_valid_r;
  logic                 out_fixed_r;
  logic                 out_pose_r;
  sample_t              out_r;

  logic [CNT_W-1:0]     n_eff;
  logic                 accept;
  logic                 emit;
  logic                 fixed_in;
  logic                 win_mode;
  logic                 push;
  logic [CNT_W-1:0]     fill_push;
  logic                 last_idx;
  sample_t              in_sample;
  sample_t              bval;
  sample_t              med;
  cell_ctrl_t           ctrl;
  sample_t              cell_sample [WINDOW_MAX];
  rank3_t               cell_rank   [WINDOW_MAX];
  logic [ACC_W-1:0]     div_in  [NUM_AXES];
  logic [ACC_W-1:0]     div_q   [NUM_AXES];
  logic                 div_done [NUM_AXES];
  logic                 div_start;
  sample_t              mean;

  // clamp the window length to 1..WINDOW_MAX
  always_comb begin
    if (wlen_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (wlen_r > CNT_W'(WINDOW_MAX)) begin
      n_eff = CNT_W'(WINDOW_MAX);
    end else begin
      n_eff = wlen_r;
    end
  end

  assign in_if.ready = (state_r == S_IDLE);
  assign accept      = in_if.valid && in_if.ready;
  assign emit        = (state_r == S_EMIT) && (!out_valid_r || out_if.ready);
  assign fixed_in    = !in_if.fix_status[2];
  assign win_mode    = (mode_r != MODE_PASS);
  assign push        = accept && fixed_in && win_mode;
  assign fill_push   = (fill_r < n_eff) ? fill_r + CNT_W'(1) : n_eff;
  assign last_idx    = ({1'b0, idx_r} == n_eff - CNT_W'(1));
  assign in_sample   = {in_if.pos_z, in_if.pos_y, in_if.pos_x};
  assign bval        = cell_sample[idx_r];

  // drive the cell row
  always_comb begin
    ctrl.shift    = push;
    ctrl.rank_clr = push;
    ctrl.rank_en  = (state_r == S_RANK);
    ctrl.bidx     = idx_r;
    ctrl.bval     = bval;
  end

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    pwm_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .my_idx      (WIN_IDX_W'(i)),
      .prev_sample ((i == 0) ? in_sample : cell_sample[(i == 0) ? 0 : i - 1]),
      .sample      (cell_sample[i]),
      .rank        (cell_rank[i])
    );
  end

  // pick the two middle ranks and take the floor of their mean
  always_comb begin
    logic [CNT_W-1:0]   lo_rank;
    logic [CNT_W-1:0]   hi_rank;
    coord_t             lo_v;
    coord_t             hi_v;
    logic [COORD_BITS:0] sum;
    lo_rank = (n_eff - CNT_W'(1)) >> 1;
    hi_rank = n_eff >> 1;
    for (int k = 0; k < NUM_AXES; k++) begin
      lo_v = '0;
      hi_v = '0;
      for (int i = 0; i < WINDOW_MAX; i++) begin
        if (CNT_W'(i) < n_eff) begin
          if ({1'b0, cell_rank[i][k]} == lo_rank) lo_v = lo_v | cell_sample[i][k];
          if ({1'b0, cell_rank[i][k]} == hi_rank) hi_v = hi_v | cell_sample[i][k];
        end
      end
      sum    = {lo_v[COORD_BITS-1], lo_v} + {hi_v[COORD_BITS-1], hi_v};
      med[k] = sum[COORD_BITS:1];
    end
  end

  // serial dividers on the magnitude of each sum
  assign div_start = (state_r == S_DSTART);
  for (genvar k = 0; k < NUM_AXES; k++) begin : g_div
    assign div_in[k] = acc_r[k][ACC_W-1] ? ACC_W'(-acc_r[k]) : ACC_W'(acc_r[k]);
    pwm_div u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .start    (div_start),
      .dividend (div_in[k]),
      .divisor  (n_eff),
      .done     (div_done[k]),
      .quot     (div_q[k])
    );
    assign mean[k] = acc_r[k][ACC_W-1] ? COORD_BITS'(-div_q[k])
                                       : div_q[k][COORD_BITS-1:0];
  end

  // sequencer, configuration and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_RESET;
      wlen_r      <= WLEN_RESET;
      fill_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_FILTER_MODE: begin
            mode_r <= cfg_wdata[1:0];
            fill_r <= '0;
          end
          REG_WINDOW_LEN: begin
            wlen_r <= cfg_wdata[CNT_W-1:0];
            fill_r <= '0;
          end
          default: ;
        endcase
      end
      // load a finished word or drop the one just taken
      if (emit) begin
        out_valid_r <= 1'b1;
        out_fixed_r <= res_fixed_r;
        out_pose_r  <= res_pose_r;
        out_r       <= res_r;
      end else if (out_if.valid && out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            res_fixed_r <= fixed_in;
            idx_r       <= '0;
            for (int k = 0; k < NUM_AXES; k++) acc_r[k] <= '0;
            if (push) fill_r <= fill_push;
            if (fixed_in && !win_mode) begin
              res_pose_r <= 1'b1;
              res_r      <= in_sample;
              state_r    <= S_EMIT;
            end else begin
              res_pose_r <= 1'b0;
              res_r      <= '0;
              if (push && (fill_push == n_eff)) begin
                state_r <= (mode_r == MODE_MEAN) ? S_SUM : S_RANK;
              end else begin
                state_r <= S_EMIT;
              end
            end
          end
        end
        S_RANK: begin
          idx_r <= idx_r + WIN_IDX_W'(1);
          if (last_idx) state_r <= S_MED;
        end
        S_MED: begin
          res_pose_r <= 1'b1;
          res_r      <= med;
          state_r    <= S_EMIT;
        end
        S_SUM: begin
          for (int k = 0; k < NUM_AXES; k++) begin
            acc_r[k] <= acc_r[k] + ACC_W'(bval[k]);
          end
          idx_r <= idx_r + WIN_IDX_W'(1);
          if (last_idx) state_r <= S_DSTART;
        end
        S_DSTART: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done[0]) begin
            res_pose_r <= 1'b1;
            res_r      <= mean;
            state_r    <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.fix_flag   = out_fixed_r;
  assign out_if.pose_valid = out_pose_r;
  assign out_if.out_x      = out_r[0];
  assign out_if.out_y      = out_r[1];
  assign out_if.out_z      = out_r[2];

  // a valid pose only comes from a fixed sample
  a_pose_fixed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.pose_valid) |-> out_if.fix_flag)
    else $error("pose valid without fix");

  // fill count never passes the window
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= n_eff)
    else $error("fill count above window length");

  // an accepted word always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != S_IDLE))
    else $error("accepted word left sequencer idle");

endmodule
